// ===== hdl/tept2_pkg.sv =====
// constants and shared types of the two-echo pseudo-t2 voxel pipeline
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package tept2_pkg;

    // fraction bits of the internal log and ratio formats
    localparam int LOG_FRAC = 28;
    // eps = 0.001 in q.30 and q.28, ln2 in q.28
    localparam logic [29:0] EPS_Q30 = 30'd1073742;
    localparam logic [27:0] EPS_Q28 = 28'd268435;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    // magnitude width of the log2 difference and of the denominator
    localparam int DMW  = 34;
    localparam int DENW = 34;
    // quotient bits: te magnitude <= 2^24, denominator >= 2^19
    localparam int QB   = 34;
    // te magnitude width and numerator width
    localparam int TMW  = 25;
    localparam int NW   = TMW + LOG_FRAC;

    typedef enum logic [1:0] {
        KIND_MASKED,
        KIND_PASS,
        KIND_CALC,
        KIND_CLAMP
    } kind_t;

    localparam logic [1:0] IDX_TE_DIFF  = 2'd0;
    localparam logic [1:0] IDX_MAX_OUT  = 2'd1;
    localparam logic [1:0] IDX_USE_MASK = 2'd2;

endpackage

`default_nettype wire

// ===== hdl/two_echo_pseudo_t2_voxel.sv =====
// top level of the two-echo pseudo-t2 voxel pipeline
// depends on tept2_pkg
`timescale 1ns / 1ps
`default_nettype none

// two-echo pseudo-t2 per voxel, fully pipelined
//
// s_* channel: one word per voxel, s_tdata holds pd and t2 samples,
// s_tuser the mask bit. m_* channel: one word per voxel, m_tdata the
// signed q19.12 result, m_tuser the result kind (masked, passed log,
// computed, clamped). cfg_* writes te_difference, max_output and use_mask,
// one register per cycle; the user writes only while the pipeline is empty
//
// a word is taken every cycle unless the receiver stalls. depth is set by
// the two 28-step squaring chains of log2 (one 29x29 multiply per stage),
// the split ln2 product and the 34-stage restoring divider (one quotient
// bit per stage).
//
// when the receiver stalls the whole pipeline holds and s_tready drops,
// nothing is lost or repeated. reset empties the pipeline and loads
// te_difference 0, max_output 2^31-1 and use_mask 1.
module two_echo_pseudo_t2_voxel
    import tept2_pkg::*;
#(
    parameter int SAMPLE_BITS = 16,
    parameter int FRAC_BITS   = 12
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // slave side: tdata = {t2_sample[15:0], pd_sample[15:0]}, pd lowest
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,
    // tuser = in_mask
    input  wire logic        s_tuser,
    // master side: tdata = pseudo_t2[31:0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,
    // tuser = result_kind[1:0]
    output logic [1:0]       m_tuser,
    // configuration write port
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data
);

    localparam int UB  = (SAMPLE_BITS < 16) ? SAMPLE_BITS : 16;
    localparam int AW  = 30 + SAMPLE_BITS;
    localparam int NSQ = LOG_FRAC;
    localparam int DW  = DMW + 1;
    localparam int RS  = LOG_FRAC - FRAC_BITS;
    // pipeline stages ahead of the output register
    localparam int S_ENC = 1;
    localparam int S_LG0 = 2;
    localparam int S_DIF = S_LG0 + NSQ + 1;
    localparam int S_PL  = S_DIF + 1;
    localparam int S_LV  = S_PL + 1;
    localparam int S_DV0 = S_LV + 1;
    localparam int NV    = S_DV0 + QB + 1;
    localparam logic signed [31:0] PASS_MAX = 32'((EPS_Q28 >> RS) + 1);

    typedef struct packed {
        logic [AW-1:0] a;
        logic [5:0]    p;
    } enc_t;

    typedef struct packed {
        logic [28:0]         m;
        logic [LOG_FRAC-1:0] frac;
        logic [5:0]          p;
    } lg_t;

    typedef struct packed {
        kind_t                   kind;
        logic signed [31:0]      pres;
        logic                    tneg;
        logic [DENW-1:0]         den;
        logic [DENW-1:0]         rem;
        logic [QB-1:0]           num;
        logic [QB-1:0]           q;
    } dv_t;

    // configuration registers
    logic signed [24:0] te_reg;
    logic [30:0]        max_reg;
    logic               use_mask_reg;

    // pipeline registers
    logic [NV-1:0]            vld_reg;
    logic                     m_tvalid_reg;
    logic [SAMPLE_BITS-1:0]   pd_reg, t2_reg;
    logic                     msk_reg [S_ENC:S_DV0];
    enc_t                     enc_reg [2];
    lg_t                      lg_reg  [2][NSQ+1];
    logic                     dneg_reg [S_DIF:S_PL];
    logic [DMW-1:0]           dmag_reg;
    logic [16:0]              dhi_reg;
    logic [44:0]              plo_reg;
    logic signed [DW-1:0]     lval_reg;
    dv_t                      dv_reg [QB+1];
    logic [31:0]              out_data_reg;
    kind_t                    out_kind_reg;

    logic adv;

    assign adv      = !m_tvalid_reg || m_tready;
    assign s_tready = adv;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_kind_reg;

    function automatic logic [5:0] lead_pos(input logic [SAMPLE_BITS-1:0] s);
        logic [5:0] pos;
        pos = 6'd20;  // eps alone has its leading one at bit 20
        for (int i = 0; i < SAMPLE_BITS; i++)
        begin
            if (s[i])
            begin
                pos = 6'(30 + i);
            end
        end
        return pos;
    endfunction

    // config writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            te_reg       <= '0;
            max_reg      <= 31'h7FFFFFFF;
            use_mask_reg <= 1'b1;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                IDX_TE_DIFF:  te_reg       <= $signed(cfg_data[24:0]);
                IDX_MAX_OUT:  max_reg      <= cfg_data;
                IDX_USE_MASK: use_mask_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // valid chain
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else if (adv)
        begin
            vld_reg      <= {vld_reg[NV-2:0], s_tvalid};
            m_tvalid_reg <= vld_reg[NV-1];
        end
    end

    // input capture, low sample bits only
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pd_reg     <= SAMPLE_BITS'(s_tdata[UB-1:0]);
            t2_reg     <= SAMPLE_BITS'(s_tdata[16+UB-1:16]);
            msk_reg[S_ENC] <= use_mask_reg && !s_tuser;
        end
    end

    // mask flag follows the log lanes up to the decision stage
    genvar g;
    generate
        for (g = S_ENC + 1; g <= S_DV0; g++)
        begin : g_msk
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    msk_reg[g] <= msk_reg[g-1];
                end
            end
        end
    endgenerate

    // log2 lanes: leading one, normalize, then squaring steps
    genvar l, k;
    generate
        for (l = 0; l < 2; l++)
        begin : g_lane
            logic [SAMPLE_BITS-1:0] smp;
            logic [AW-1:0]          a_w;
            logic [AW-1:0]          sh_w;

            assign smp = (l == 0) ? pd_reg : t2_reg;
            assign a_w = {smp, 30'd0} + AW'(EPS_Q30);

            always_comb
            begin
                if (enc_reg[l].p < 6'd28)
                begin
                    sh_w = enc_reg[l].a << (6'd28 - enc_reg[l].p);
                end
                else
                begin
                    sh_w = enc_reg[l].a >> (enc_reg[l].p - 6'd28);
                end
            end

            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    enc_reg[l].a         <= a_w;
                    enc_reg[l].p         <= lead_pos(smp);
                    lg_reg[l][0].m       <= sh_w[28:0];
                    lg_reg[l][0].frac    <= '0;
                    lg_reg[l][0].p       <= enc_reg[l].p;
                end
            end

            for (k = 1; k <= NSQ; k++)
            begin : g_sq
                logic [57:0] sq_w;
                assign sq_w = 58'(lg_reg[l][k-1].m) * 58'(lg_reg[l][k-1].m);
                always_ff @(posedge clk)
                begin
                    if (adv)
                    begin
                        lg_reg[l][k].m    <= sq_w[57] ? sq_w[57:29] : sq_w[56:28];
                        lg_reg[l][k].frac <= {lg_reg[l][k-1].frac[LOG_FRAC-2:0], sq_w[57]};
                        lg_reg[l][k].p    <= lg_reg[l][k-1].p;
                    end
                end
            end
        end
    endgenerate

    // log2 difference
    logic signed [6:0]    pdiff_w;
    logic signed [DW-1:0] d_w;
    assign pdiff_w = $signed({1'b0, lg_reg[0][NSQ].p}) - $signed({1'b0, lg_reg[1][NSQ].p});
    assign d_w = $signed({pdiff_w, {LOG_FRAC{1'b0}}})
               + $signed(DW'({1'b0, lg_reg[0][NSQ].frac}))
               - $signed(DW'({1'b0, lg_reg[1][NSQ].frac}));

    // ln2 product in two halves, rounded half away from zero
    logic [61:0]          tot_w;
    logic [DMW-1:0]       pmag_w;
    assign tot_w  = 62'(plo_reg) + ((62'(dhi_reg) * 62'(LN2_Q28)) << 17)
                  + (62'd1 << (LOG_FRAC - 1));
    assign pmag_w = tot_w[61:LOG_FRAC];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dneg_reg[S_DIF] <= d_w < 0;
            dmag_reg        <= (d_w < 0) ? DMW'(-d_w) : DMW'(d_w);
            dneg_reg[S_PL]  <= dneg_reg[S_DIF];
            dhi_reg         <= dmag_reg[33:17];
            plo_reg         <= 45'(dmag_reg[16:0]) * 45'(LN2_Q28);
            lval_reg        <= dneg_reg[S_PL] ? -$signed({1'b0, pmag_w})
                                              : $signed({1'b0, pmag_w});
        end
    end

    // decision: mask, pass-through or division setup
    logic [DMW-1:0]  lmag_w;
    logic [DMW-1:0]  rnd_w;
    logic [DENW-1:0] den_w;
    logic [TMW-1:0]  tmag_w;
    logic [NW-1:0]   num_w;
    dv_t             dec_w;

    always_comb
    begin
        lmag_w = (lval_reg < 0) ? DMW'(-lval_reg) : DMW'(lval_reg);
        rnd_w  = (lmag_w + (DMW'(1) << (RS - 1))) >> RS;
        den_w  = DENW'(lval_reg) + DENW'(EPS_Q28);
        tmag_w = (te_reg < 0) ? TMW'(-te_reg) : TMW'(te_reg);
        num_w  = {tmag_w, {LOG_FRAC{1'b0}}} + NW'(den_w >> 1);
        dec_w.pres = (lval_reg < 0) ? -$signed(32'(rnd_w)) : $signed(32'(rnd_w));
        dec_w.tneg = te_reg < 0;
        dec_w.den  = den_w;
        dec_w.rem  = DENW'(num_w >> QB);
        dec_w.num  = num_w[QB-1:0];
        dec_w.q    = '0;
        if (msk_reg[S_DV0])
        begin
            dec_w.kind = KIND_MASKED;
            dec_w.pres = '0;
        end
        else if (lval_reg < $signed(DW'(EPS_Q28)))
        begin
            dec_w.kind = KIND_PASS;
        end
        else
        begin
            dec_w.kind = KIND_CALC;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            dv_reg[0] <= dec_w;
        end
    end

    // restoring divider, one quotient bit per stage
    generate
        for (k = 1; k <= QB; k++)
        begin : g_div
            logic [DENW:0] t_w;
            logic          ge_w;
            dv_t           nx_w;
            assign t_w  = {dv_reg[k-1].rem, dv_reg[k-1].num[QB-1]};
            assign ge_w = t_w >= {1'b0, dv_reg[k-1].den};
            always_comb
            begin
                nx_w     = dv_reg[k-1];
                nx_w.rem = ge_w ? DENW'(t_w - {1'b0, dv_reg[k-1].den}) : DENW'(t_w);
                nx_w.num = {dv_reg[k-1].num[QB-2:0], 1'b0};
                nx_w.q   = {dv_reg[k-1].q[QB-2:0], ge_w};
            end
            always_ff @(posedge clk)
            begin
                if (adv)
                begin
                    dv_reg[k] <= nx_w;
                end
            end
        end
    endgenerate

    // sign, saturation and clamp
    logic signed [31:0] sat_w;
    logic [31:0]        res_w;
    kind_t              kind_w;

    always_comb
    begin
        if (dv_reg[QB].tneg)
        begin
            sat_w = (dv_reg[QB].q > QB'(64'h80000000)) ? 32'sh80000000
                                                       : $signed(32'(-dv_reg[QB].q));
        end
        else
        begin
            sat_w = (dv_reg[QB].q > QB'(64'h7FFFFFFF)) ? 32'sh7FFFFFFF
                                                       : $signed(dv_reg[QB].q[31:0]);
        end
        kind_w = dv_reg[QB].kind;
        res_w  = dv_reg[QB].pres;
        if (dv_reg[QB].kind == KIND_CALC)
        begin
            res_w = sat_w;
            if (use_mask_reg && ($signed({sat_w[31], sat_w}) > $signed({2'b00, max_reg})))
            begin
                res_w  = {1'b0, max_reg};
                kind_w = KIND_CLAMP;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_data_reg <= res_w;
            out_kind_reg <= kind_w;
        end
    end

    // masked voxels come out as zero
    a_masked_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_MASKED |-> m_tdata == 32'd0)
        else $error("masked voxel with nonzero result");

    // a clamped word carries max_output exactly
    a_clamp_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CLAMP |-> use_mask_reg && m_tdata == {1'b0, max_reg})
        else $error("clamped word does not match max_output");

    // computed words never exceed the clamp when masking is on
    a_calc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_CALC && use_mask_reg
        |-> $signed({m_tdata[31], m_tdata}) <= $signed({2'b00, max_reg}))
        else $error("computed word above max_output");

    // a passed log value stays below eps after rounding
    a_pass_bound: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser == KIND_PASS |-> $signed(m_tdata) <= PASS_MAX)
        else $error("passed log value above eps");

endmodule

`default_nettype wire

// ===== bench/pt2_checker.sv =====
// result predictor and scoreboard for the two-echo pseudo-t2 voxel pipeline
// watches both stream channels and the register port; depends on tept2_pkg
`timescale 1ns / 1ps

module pt2_checker
    import tept2_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    input  wire logic        s_tready,
    input  wire logic [31:0] s_tdata,
    input  wire logic        s_tuser,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [31:0] m_tdata,
    input  wire logic [1:0]  m_tuser,
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [30:0] cfg_data,
    output int               fail_count,
    output int               pending
);

    typedef struct packed {
        logic [31:0] value;
        kind_t       kind;
    } t2_result_t;

    t2_result_t           t2_expected[$];
    logic signed [24:0]   te_reg;
    logic [30:0]          max_reg;
    logic                 mask_reg;

    assign pending = t2_expected.size();

    // log2 of a q.30 value, q.28 result, truncating squarings
    function automatic longint log2_q28(input logic [63:0] a);
        int          p;
        logic [63:0] m;
        logic [63:0] frac;
        p = 63;
        frac = 0;
        while (p > 0 && a[p] == 1'b0)
            p--;
        if (p >= 28)
            m = a >> (p - 28);
        else
            m = a << (28 - p);
        for (int i = 0; i < 28; i++)
        begin
            m = (m * m) >> 28;
            frac = frac << 1;
            if (m >= (64'd2 << 28))
            begin
                m = m >> 1;
                frac[0] = 1'b1;
            end
        end
        return longint'(p - 30) * (longint'(1) << 28) + longint'(frac);
    endfunction

    function automatic t2_result_t predict_voxel(input logic [15:0] pd,
                                                 input logic [15:0] t2,
                                                 input logic in_mask);
        t2_result_t  r;
        longint      d;
        longint      lval;
        longint      res;
        logic [63:0] mag;
        logic [63:0] den;
        logic [63:0] tmag;
        logic [63:0] q;
        bit          neg;
        if (mask_reg && !in_mask)
        begin
            r.value = 0;
            r.kind = KIND_MASKED;
            return r;
        end
        d = log2_q28(({48'd0, pd} << 30) + 64'd1073742)
          - log2_q28(({48'd0, t2} << 30) + 64'd1073742);
        neg = d < 0;
        mag = neg ? -d : d;
        mag = (mag * 64'd186065279 + (64'd1 << 27)) >> 28;
        lval = neg ? -longint'(mag) : longint'(mag);
        if (lval < 268435)
        begin
            // small log passes through, rounded half away from zero
            mag = ((neg ? -lval : lval) + (64'd1 << 15)) >> 16;
            res = neg ? -longint'(mag) : longint'(mag);
            r.kind = KIND_PASS;
        end
        else
        begin
            den = lval + 268435;
            tmag = (te_reg < 0) ? -longint'(te_reg) : longint'(te_reg);
            q = ((tmag << 28) + den / 2) / den;
            if (te_reg < 0)
                res = (q > 64'd2147483648) ? -64'sd2147483648 : -longint'(q);
            else
                res = (q > 64'd2147483647) ? 64'sd2147483647 : longint'(q);
            r.kind = KIND_CALC;
            if (mask_reg && res > longint'(max_reg))
            begin
                res = longint'(max_reg);
                r.kind = KIND_CLAMP;
            end
        end
        r.value = res[31:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        t2_result_t exp_r;
        if (!rst_n)
        begin
            te_reg <= 0;
            max_reg <= 31'h7fffffff;
            mask_reg <= 1'b1;
            fail_count <= 0;
            t2_expected.delete();
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    IDX_TE_DIFF:  te_reg <= cfg_data[24:0];
                    IDX_MAX_OUT:  max_reg <= cfg_data;
                    IDX_USE_MASK: mask_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
                t2_expected.push_back(predict_voxel(s_tdata[15:0], s_tdata[31:16],
                                                    s_tuser));
            if (m_tvalid && m_tready)
            begin
                if (t2_expected.size() == 0)
                begin
                    if (fail_count < 10)
                        $display("unexpected word: value %h kind %0d", m_tdata, m_tuser);
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = t2_expected.pop_front();
                    if (m_tdata !== exp_r.value || m_tuser !== exp_r.kind)
                    begin
                        if (fail_count < 10)
                            $display("mismatch: expected %h/%0d got %h/%0d",
                                     exp_r.value, exp_r.kind, m_tdata, m_tuser);
                        fail_count <= fail_count + 1;
                    end
                end
            end
        end
    end

endmodule

// ===== bench/tb.sv =====
// top of the pseudo-t2 voxel bench: clock, reset, voxel stimulus and verdict
// depends on tept2_pkg, pt2_checker and the two_echo_pseudo_t2_voxel rtl
`timescale 1ns / 1ps

module tb;
    import tept2_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    // pd_sample[15:0], t2_sample[31:16]
    logic [31:0] s_tdata;
    // in_mask
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    // pseudo_t2[31:0]
    logic [31:0] m_tdata;
    // result_kind[1:0]
    logic [1:0]  m_tuser;
    logic        cfg_we;
    logic [1:0]  cfg_index;
    logic [30:0] cfg_data;

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_stall_pct;
    bit hold_off;
    int cycle_count;

    two_echo_pseudo_t2_voxel dut (.*);

    pt2_checker checker_i (.*);

    initial
    begin
        clk = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_we = 1'b0;
        cfg_index = IDX_TE_DIFF;
        cfg_data = '0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 1'b0;
    end

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // runaway guard: 1255 items at worst stalls plus long hold-offs fit easily
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end
    initial cycle_count = 0;

    // receiver: random stalls, or a long hold-off while the sender keeps going
    always @(posedge clk)
    begin
        if (!rst_n || hold_off)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    task automatic write_reg(input logic [1:0] idx, input logic [30:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    // offer one voxel, honoring the sender idle rate, and wait for acceptance
    task automatic send_voxel(input logic [15:0] pd, input logic [15:0] t2,
                              input logic in_mask);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {t2, pd};
        s_tuser <= in_mask;
        do
            @(posedge clk);
        while (!s_tready);
    endtask

    task automatic drain_pipe();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // pipeline latency margin before touching registers
        repeat (80) @(posedge clk);
    endtask

    // samples biased toward extremes and small values
    function automatic logic [15:0] pick_sample();
        case ($urandom_range(5))
            0: return 16'(0);
            1: return 16'hffff;
            2: return 16'($urandom_range(15));
            default: return 16'($urandom);
        endcase
    endfunction

    task automatic random_phase(input int count);
        logic [15:0] pd;
        logic [15:0] t2;
        for (int i = 0; i < count; i++)
        begin
            pd = pick_sample();
            // near-equal pairs land around the pass-through threshold
            if ($urandom_range(3) == 0)
                t2 = pd - 16'($urandom_range(3)) + 16'($urandom_range(3));
            else
                t2 = pick_sample();
            send_voxel(pd, t2, 1'($urandom_range(3) != 0));
        end
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset settings, te 0 so computed words are zero
        send_voxel(16'd0, 16'd0, 1'b1);
        send_voxel(16'hffff, 16'd0, 1'b1);
        send_voxel(16'd0, 16'hffff, 1'b1);
        send_voxel(16'd5, 16'd5, 1'b0);
        drain_pipe();
        write_reg(IDX_TE_DIFF, 31'(25'h0ffffff));
        write_reg(IDX_MAX_OUT, 31'd100000);
        // clamp, saturation-range ratio, small log, masked out
        send_voxel(16'd2, 16'd1, 1'b1);
        send_voxel(16'hffff, 16'd0, 1'b1);
        send_voxel(16'hffff, 16'hfffe, 1'b1);
        send_voxel(16'd1, 16'd3, 1'b1);
        send_voxel(16'd100, 16'd10, 1'b0);
        send_voxel(16'd1001, 16'd1000, 1'b1);
        drain_pipe();
        write_reg(IDX_USE_MASK, 31'd0);
        write_reg(IDX_TE_DIFF, 31'(25'h1000000));
        // unmasked: mask bit ignored, no clamp, most negative te
        send_voxel(16'd2, 16'd1, 1'b0);
        send_voxel(16'hffff, 16'd0, 1'b0);
        send_voxel(16'd3, 16'd1, 1'b1);
        send_voxel(16'd0, 16'd7, 1'b0);
        send_voxel(16'd1, 16'd0, 1'b1);
        drain_pipe();

        // random phases across register settings and idle mixes
        for (int ph = 0; ph < 8; ph++)
        begin
            write_reg(IDX_TE_DIFF, 31'($urandom_range(1) ? $urandom : $urandom_range(200000)));
            write_reg(IDX_MAX_OUT, (ph == 3) ? 31'd0 : 31'($urandom));
            write_reg(IDX_USE_MASK, 31'(ph % 2));
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 27; recv_stall_pct = 27; end
            endcase
            if (ph == 2)
            begin
                // long receiver hold-off while voxels keep coming
                send_idle_pct = 0;
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (300) @(posedge clk);
                        hold_off = 1'b0;
                    end
                    random_phase(150);
                join
            end
            else
                random_phase(150);
            // sender pause until every result is back
            drain_pipe();
        end

        write_reg(IDX_MAX_OUT, 31'h7fffffff);
        write_reg(IDX_USE_MASK, 31'd1);
        send_idle_pct = 27;
        recv_stall_pct = 27;
        random_phase(40);
        drain_pipe();

        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
